[rtl/core/lvps_pkg.sv]
// Shared types, constants and helpers for the local variance pixel selector.
package lvps_pkg;

  // Frame limits and register reset values
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int DIM_MIN      = 3;
  localparam int RESET_WIDTH  = 1136;
  localparam int RESET_HEIGHT = 852;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // Counter and dimension widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);
  localparam int POS_W  = 11;

  // Statistic widths: column of 9 values, window of 27 values, score terms
  localparam int CSUM_W  = 12;
  localparam int CSQ_W   = 20;
  localparam int WSUM_W  = 13;
  localparam int WSQ_W   = 21;
  localparam int SSQ_W   = 26;
  localparam int Q9_W    = 24;
  localparam int SCORE_W = 27;
  localparam int WIN_N   = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] first_blue;
    logic [7:0] first_green;
    logic [7:0] first_red;
    logic [7:0] second_blue;
    logic [7:0] second_green;
    logic [7:0] second_red;
  } pixel_t;

  typedef struct packed {
    logic [7:0]       out_blue;
    logic [7:0]       out_green;
    logic [7:0]       out_red;
    logic             took_first;
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_col;
  } result_t;

  typedef struct packed {
    logic [CSUM_W-1:0] sum;
    logic [CSQ_W-1:0]  sq;
  } img_stat_t;

  typedef struct packed {
    img_stat_t first;
    img_stat_t second;
  } col_stat_t;

  typedef struct packed {
    col_stat_t        stat;
    pixel_t           cand;
    logic             emit;
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_col;
  } queue_entry_t;

  // Sum and sum of squares over nine channel values of one image column
  function automatic img_stat_t chan_stat(input logic [8:0][7:0] v);
    img_stat_t st;
    st = '0;
    for (int i = 0; i < 9; i++) begin
      st.sum = st.sum + CSUM_W'(v[i]);
      st.sq  = st.sq + CSQ_W'({8'b0, v[i]} * {8'b0, v[i]});
    end
    return st;
  endfunction

endpackage

[rtl/core/lvps_front.sv]
// Front part: config registers, raster counters, line store and column statistics.
module lvps_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [lvps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lvps_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  lvps_pkg::pixel_t             pixel,
  output logic                         push,
  output lvps_pkg::queue_entry_t       push_entry,
  input  logic                         queue_full,
  output logic                         restart
);
  import lvps_pkg::*;

  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  logic [WDIM_W-1:0] width_eff;
  logic [HDIM_W-1:0] height_eff;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              col_last;
  logic              row_last;
  logic              accept;
  logic              advance;

  // Line store: newer row in the upper half, older row in the lower half
  logic [2*$bits(pixel_t)-1:0] line_mem [MAX_WIDTH];
  logic [2*$bits(pixel_t)-1:0] line_rd;
  pixel_t                      old_pix;
  pixel_t                      new_pix;

  // Work stage that holds the item while the line store data arrives
  logic             stg_valid;
  pixel_t           stg_pix;
  logic [COL_W-1:0] stg_col;
  logic             stg_emit;
  logic [POS_W-1:0] stg_centre_row;
  logic [POS_W-1:0] stg_centre_col;

  assign restart = cfg_valid &&
                   (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(RESET_WIDTH);
      frame_height <= CFG_W'(RESET_HEIGHT);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate frame size to the supported range
  always_comb begin
    if (frame_width < CFG_W'(DIM_MIN)) begin
      width_eff = WDIM_W'(DIM_MIN);
    end else if (WDIM_W'(frame_width) > WDIM_W'(MAX_WIDTH)) begin
      width_eff = WDIM_W'(MAX_WIDTH);
    end else begin
      width_eff = WDIM_W'(frame_width);
    end
    if (frame_height < CFG_W'(DIM_MIN)) begin
      height_eff = HDIM_W'(DIM_MIN);
    end else if (HDIM_W'(frame_height) > HDIM_W'(MAX_HEIGHT)) begin
      height_eff = HDIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = HDIM_W'(frame_height);
    end
  end

  assign col_last = (WDIM_W'(col) == width_eff - WDIM_W'(1));
  assign row_last = (HDIM_W'(row) == height_eff - HDIM_W'(1));

  // Stall only while the work stage is blocked by a full queue
  assign advance     = stg_valid && !queue_full;
  assign pixel_stall = stg_valid && queue_full;
  assign accept      = pixel_valid && !pixel_stall;

  // Advance raster position, restart on a register write
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Read the column on accept, write it back when the item leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col];
    end
    if (advance) begin
      line_mem[stg_col] <= {stg_pix, new_pix};
    end
  end

  assign {new_pix, old_pix} = line_rd;

  // Hold the accepted item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_pix        <= pixel;
      stg_col        <= col;
      stg_emit       <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
      stg_centre_row <= POS_W'(row - ROW_W'(1));
      stg_centre_col <= POS_W'(col - COL_W'(1));
    end
  end

  // Build the column statistics and push to the queue
  assign push = advance;

  always_comb begin
    push_entry.stat.first = chan_stat({old_pix.first_blue, old_pix.first_green,
                                       old_pix.first_red, new_pix.first_blue,
                                       new_pix.first_green, new_pix.first_red,
                                       stg_pix.first_blue, stg_pix.first_green,
                                       stg_pix.first_red});
    push_entry.stat.second = chan_stat({old_pix.second_blue, old_pix.second_green,
                                        old_pix.second_red, new_pix.second_blue,
                                        new_pix.second_green, new_pix.second_red,
                                        stg_pix.second_blue, stg_pix.second_green,
                                        stg_pix.second_red});
    push_entry.cand       = new_pix;
    push_entry.emit       = stg_emit;
    push_entry.centre_row = stg_centre_row;
    push_entry.centre_col = stg_centre_col;
  end

endmodule

[rtl/core/lvps_queue.sv]
// Short queue that decouples the front part from the back part.
module lvps_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lvps_pkg::queue_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output lvps_pkg::queue_entry_t pop_entry
);
  import lvps_pkg::*;

  queue_entry_t      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = entries[rd_ptr];

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/core/lvps_back.sv]
// Back part: 3x3 window sums, variance scores, pick and result register.
module lvps_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  logic                   pop_valid,
  input  lvps_pkg::queue_entry_t pop_entry,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output lvps_pkg::result_t      result
);
  import lvps_pkg::*;

  // Window of column statistics and the two centre candidates
  col_stat_t win [WIN_N];
  pixel_t    cand_old;
  pixel_t    cand_new;

  // Window stage
  logic             p1_valid;
  logic             p1_emit;
  logic [POS_W-1:0] p1_row;
  logic [POS_W-1:0] p1_col;
  logic [WSUM_W-1:0] sum_first;
  logic [WSUM_W-1:0] sum_second;
  logic [WSQ_W-1:0]  sq_first;
  logic [WSQ_W-1:0]  sq_second;

  // Product stage
  logic              p2_valid;
  logic [SSQ_W-1:0]  p2_ssq_first;
  logic [SSQ_W-1:0]  p2_ssq_second;
  logic [Q9_W-1:0]   p2_q9_first;
  logic [Q9_W-1:0]   p2_q9_second;
  pixel_t            p2_pix;
  logic [POS_W-1:0]  p2_row;
  logic [POS_W-1:0]  p2_col;

  logic                out_free;
  logic                p2_free;
  logic                p1_free;
  logic                p1_move;
  logic [SCORE_W-1:0]  lhs;
  logic [SCORE_W-1:0]  rhs;
  logic                pick_first;

  assign out_free = !result_valid || !result_stall;
  assign p2_free  = !p2_valid || out_free;
  assign p1_free  = !p1_valid || !p1_emit || p2_free;
  assign p1_move  = p1_valid && p1_emit && p2_free;
  assign pop      = pop_valid && p1_free;

  // Shift the window and candidates on every item
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < WIN_N; i++) begin
        win[i] <= '0;
      end
      cand_old <= '0;
      cand_new <= '0;
    end else if (pop) begin
      for (int i = 0; i < WIN_N - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WIN_N-1] <= pop_entry.stat;
      cand_old     <= cand_new;
      cand_new     <= pop_entry.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (pop) begin
      p1_valid <= 1'b1;
    end else if (p1_free) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p1_emit <= pop_entry.emit;
      p1_row  <= pop_entry.centre_row;
      p1_col  <= pop_entry.centre_col;
    end
  end

  // Add the three column statistics per image
  always_comb begin
    sum_first  = '0;
    sum_second = '0;
    sq_first   = '0;
    sq_second  = '0;
    for (int i = 0; i < WIN_N; i++) begin
      sum_first  = sum_first + WSUM_W'(win[i].first.sum);
      sum_second = sum_second + WSUM_W'(win[i].second.sum);
      sq_first   = sq_first + WSQ_W'(win[i].first.sq);
      sq_second  = sq_second + WSQ_W'(win[i].second.sq);
    end
  end

  // Square the sums and scale the squares by nine
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p1_move) begin
      p2_valid <= 1'b1;
    end else if (out_free) begin
      p2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      p2_ssq_first  <= SSQ_W'(sum_first) * SSQ_W'(sum_first);
      p2_ssq_second <= SSQ_W'(sum_second) * SSQ_W'(sum_second);
      p2_q9_first   <= Q9_W'({sq_first, 3'b000}) + Q9_W'(sq_first);
      p2_q9_second  <= Q9_W'({sq_second, 3'b000}) + Q9_W'(sq_second);
      p2_pix        <= cand_old;
      p2_row        <= p1_row;
      p2_col        <= p1_col;
    end
  end

  // Compare 9Q - S^2 across images with both squares moved to the other side
  assign lhs        = SCORE_W'(p2_q9_first) + SCORE_W'(p2_ssq_second);
  assign rhs        = SCORE_W'(p2_q9_second) + SCORE_W'(p2_ssq_first);
  assign pick_first = (lhs >= rhs);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p2_valid) begin
      result.out_blue   <= pick_first ? p2_pix.first_blue  : p2_pix.second_blue;
      result.out_green  <= pick_first ? p2_pix.first_green : p2_pix.second_green;
      result.out_red    <= pick_first ? p2_pix.first_red   : p2_pix.second_red;
      result.took_first <= pick_first;
      result.centre_row <= p2_row;
      result.centre_col <= p2_col;
    end
  end

endmodule

[rtl/core/local_variance_pixel_select.sv]
// Top level of the local variance pixel selector.
//
//   channel  direction  handshake                  payload
//   pixel    in         pixel_valid / pixel_stall  pixel (lvps_pkg::pixel_t)
//   result   out        result_valid / result_stall result (lvps_pkg::result_t)
//   config   in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One pixel pair per cycle sustained when nothing stalls; the line store has one
// read and one write port, and each pair uses each once. An item passes the work
// stage, queue, window, product and result stages. Border pixels give no result.
// Reset is synchronous on rst; the line store is not cleared and needs no pass.
// pixel_stall rises only when the two-entry queue is full; result_stall holds the
// result register and backs up through the queue.
module local_variance_pixel_select (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lvps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lvps_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  lvps_pkg::pixel_t               pixel,
  output logic                           result_valid,
  input  logic                           result_stall,
  output lvps_pkg::result_t              result
);
  import lvps_pkg::*;

  logic         push;
  queue_entry_t push_entry;
  logic         queue_full;
  logic         pop;
  logic         not_empty;
  queue_entry_t pop_entry;
  logic         restart;

  // Writes are taken at any time
  assign cfg_ready = 1'b1;

  lvps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .push        (push),
    .push_entry  (push_entry),
    .queue_full  (queue_full),
    .restart     (restart)
  );

  lvps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .pop_entry  (pop_entry)
  );

  lvps_back u_back (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .pop_valid    (not_empty),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[rtl/core/lvps_checker.sv]
// Port-level checks for the local variance pixel selector, bound to the top level.
module lvps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [lvps_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [lvps_pkg::CFG_W-1:0]     cfg_data,
  input logic                           pixel_valid,
  input logic                           pixel_stall,
  input lvps_pkg::pixel_t               pixel,
  input logic                           result_valid,
  input logic                           result_stall,
  input lvps_pkg::result_t              result
);
  import lvps_pkg::*;

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Drop border pixels: no result at row or column zero
  a_no_border: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.centre_row != '0) && (result.centre_col != '0))
    else $error("border pixel emitted");

  // Clear the result register out of reset
  a_reset_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // Accept input right after reset
  a_reset_stall: assert property (@(posedge clk)
    rst |=> !pixel_stall)
    else $error("pixel stall after reset");

endmodule

bind local_variance_pixel_select lvps_checker u_lvps_checker (.*);

[bench/local_variance_pixel_select_tb.sv]
// Self-checking testbench for the local variance pixel selector.
module local_variance_pixel_select_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lvps_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_GAP      = 40;
  localparam int WINDOW_CELLS = 9;
  localparam int SHOW_LIMIT   = 10;

  // Indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {
    PIX_RANDOM,
    PIX_EXTREME,
    PIX_SMOOTH,
    PIX_SAME,
    PIX_FLAT_FIRST,
    PIX_FLAT_SECOND
  } pix_style_t;

  // Predicts the chosen centre pixels and checks the block's results against them
  class pick_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pixel_t           older_row[MAX_WIDTH];
    pixel_t           newer_row[MAX_WIDTH];
    int unsigned      col_sum[3][2];
    int unsigned      col_sq[3][2];
    pixel_t           centre_cand[2];
    int unsigned      col_pos;
    int unsigned      row_pos;
    result_t          expected_picks[$];
    int               mismatches;

    function new();
      width_reg  = CFG_W'(RESET_WIDTH);
      height_reg = CFG_W'(RESET_HEIGHT);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      mismatches = 0;
      restart();
    endfunction

    // Return to the start of a frame; line stores keep their contents
    function void restart();
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 2; k++) begin
          col_sum[i][k] = 0;
          col_sq[i][k]  = 0;
        end
      end
      centre_cand[0] = '0;
      centre_cand[1] = '0;
      col_pos = 0;
      row_pos = 0;
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < DIM_MIN) return DIM_MIN;
      if (v > hi) return hi;
      return v;
    endfunction

    static function int unsigned chan(pixel_t p, int img, int ch);
      case (img * 3 + ch)
        0:       return p.first_blue;
        1:       return p.first_green;
        2:       return p.first_red;
        3:       return p.second_blue;
        4:       return p.second_green;
        default: return p.second_red;
      endcase
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) width_reg = data;
      else if (idx == REG_FRAME_HEIGHT) height_reg = data;
      else return;
      restart();
    endfunction

    // Advance the window by one accepted item and queue the pick it causes
    function void note_pixel(pixel_t p);
      int unsigned w, h, c, r, s, q, v;
      longint      tot_s, tot_q;
      longint      score[2];
      pixel_t      oldp, newp, pick;
      result_t     want;
      int          k;
      bit          first;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      c = col_pos;
      r = row_pos;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;

      oldp = older_row[c];
      newp = newer_row[c];
      older_row[c] = newp;
      newer_row[c] = p;

      // Shift column stats and add the new column
      col_sum[0] = col_sum[1];
      col_sum[1] = col_sum[2];
      col_sq[0]  = col_sq[1];
      col_sq[1]  = col_sq[2];
      for (int img = 0; img < 2; img++) begin
        s = 0;
        q = 0;
        for (int ch = 0; ch < 3; ch++) begin
          v = chan(oldp, img, ch);
          s += v;
          q += v * v;
          v = chan(newp, img, ch);
          s += v;
          q += v * v;
          v = chan(p, img, ch);
          s += v;
          q += v * v;
        end
        col_sum[2][img] = s;
        col_sq[2][img]  = q;
      end
      centre_cand[0] = centre_cand[1];
      centre_cand[1] = newp;

      // Score both windows on interior centres
      if (r >= 2 && c >= 2) begin
        for (int img = 0; img < 2; img++) begin
          tot_s = 0;
          tot_q = 0;
          for (int i = 0; i < 3; i++) begin
            tot_s += col_sum[i][img];
            tot_q += col_sq[i][img];
          end
          score[img] = WINDOW_CELLS * tot_q - tot_s * tot_s;
        end
        first = (score[0] >= score[1]);
        k = first ? 0 : 1;
        pick = centre_cand[0];
        want.out_blue   = 8'(chan(pick, k, 0));
        want.out_green  = 8'(chan(pick, k, 1));
        want.out_red    = 8'(chan(pick, k, 2));
        want.took_first = first;
        want.centre_row = POS_W'(r - 1);
        want.centre_col = POS_W'(c - 1);
        expected_picks.push_back(want);
      end

      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    // Compare one accepted result with the oldest expected pick
    function void check_pick(result_t got);
      result_t want;
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected pick at row %0d col %0d", got.centre_row, got.centre_col);
        return;
      end
      want = expected_picks.pop_front();
      if (got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
          got.out_red !== want.out_red || got.took_first !== want.took_first ||
          got.centre_row !== want.centre_row || got.centre_col !== want.centre_col) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("pick mismatch: expected bgr %02x %02x %02x first %0d at %0d,%0d",
                   want.out_blue, want.out_green, want.out_red, want.took_first,
                   want.centre_row, want.centre_col);
          $display("               got      bgr %02x %02x %02x first %0d at %0d,%0d",
                   got.out_blue, got.out_green, got.out_red, got.took_first,
                   got.centre_row, got.centre_col);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 pixel_valid  = 1'b0;
  logic                 pixel_stall;
  pixel_t               pixel        = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;

  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             smooth_base   = 128;
  int             cycles        = 0;
  pick_scoreboard board         = new();

  local_variance_pixel_select u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Accept results and drive random stall
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) board.check_pick(result);
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Build a pixel pair with all first channels a and all second channels b
  function automatic pixel_t flat_pair(logic [7:0] a, logic [7:0] b);
    pixel_t p;
    p = '{a, a, a, b, b, b};
    return p;
  endfunction

  function automatic pixel_t make_pixel(pix_style_t style);
    logic [63:0] raw;
    pixel_t      p;
    int          b;
    raw = {$urandom(), $urandom()};
    p = raw[47:0];
    case (style)
      PIX_EXTREME: begin
        for (int i = 0; i < 6; i++) p[i*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      PIX_SMOOTH: begin
        for (int i = 0; i < 6; i++) begin
          b = smooth_base + int'($urandom_range(6)) - 3;
          if (b < 0) b = 0;
          if (b > 255) b = 255;
          p[i*8 +: 8] = 8'(b);
        end
      end
      PIX_SAME: begin
        p.second_blue  = p.first_blue;
        p.second_green = p.first_green;
        p.second_red   = p.first_red;
      end
      PIX_FLAT_FIRST: begin
        p.first_blue  = 8'(smooth_base);
        p.first_green = 8'(smooth_base);
        p.first_red   = 8'(smooth_base);
      end
      PIX_FLAT_SECOND: begin
        p.second_blue  = 8'(smooth_base);
        p.second_green = 8'(smooth_base);
        p.second_red   = 8'(smooth_base);
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim(int hi);
    if ($urandom_range(7) == 0) return CFG_W'($urandom_range(DIM_MIN - 1));
    return CFG_W'($urandom_range(hi, DIM_MIN));
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    board.note_pixel(p);
  endtask

  // Drop valid, wait for all picks, then let the pipeline empty
  task automatic settle();
    pixel_valid <= 1'b0;
    while (board.expected_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    settle();
    if ($urandom_range(1)) begin
      write_reg(REG_FRAME_WIDTH, w, 1'b0);
      write_reg(REG_FRAME_HEIGHT, h, 1'b1);
    end else begin
      write_reg(REG_FRAME_HEIGHT, h, 1'b0);
      write_reg(REG_FRAME_WIDTH, w, 1'b1);
    end
  endtask

  // Configure a frame size and stream items of one flavor with some noise
  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int n_items);
    pix_style_t style;
    style = pix_style_t'($urandom_range(PIX_FLAT_SECOND));
    case ($urandom_range(3))
      0:       smooth_base = 0;
      1:       smooth_base = 255;
      default: smooth_base = $urandom_range(255);
    endcase
    set_frame(w, h);
    repeat (n_items)
      send_pixel(make_pixel(($urandom_range(9) == 0) ? PIX_RANDOM : style));
  endtask

  initial begin
    int done_items;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 82;

    // Flat windows in both images tie, so the first image wins
    set_frame(12'd0, 12'd1);
    repeat (9) send_pixel(flat_pair(8'hFF, 8'h00));

    // Checkered second image beats flat first; spare writes must not restart
    for (int i = 0; i < 4; i++) send_pixel(flat_pair(8'h80, (i % 2) ? 8'hFF : 8'h00));
    settle();
    write_reg(REG_SPARE_A, 12'hFFF, 1'b0);
    write_reg(REG_SPARE_B, 12'h000, 1'b1);
    for (int i = 4; i < 9; i++) send_pixel(flat_pair(8'h80, (i % 2) ? 8'hFF : 8'h00));

    // Random frames, sender idles less than receiver
    done_items = 0;
    while (done_items < 480) begin
      n = $urandom_range(120, 20);
      run_phase(pick_dim(12), pick_dim(9), n);
      done_items += n;
    end

    // Swap idling
    send_idle_pct = 82;
    recv_idle_pct = 34;
    while (done_items < 960) begin
      n = $urandom_range(120, 20);
      run_phase(pick_dim(12), pick_dim(9), n);
      done_items += n;
    end

    // No idling; widest and tallest frames first
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(12'hFFF, 12'd3, 120);
    run_phase(12'd3, 12'hFFF, 150);
    run_phase(12'd2048, 12'd2048, 60);
    done_items += 120 + 150 + 60;
    while (done_items < 1450) begin
      n = $urandom_range(120, 20);
      run_phase(pick_dim(12), pick_dim(9), n);
      done_items += n;
    end

    settle();
    if (board.mismatches == 0 && board.expected_picks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lvps_pkg.sv
rtl/core/lvps_front.sv
rtl/core/lvps_queue.sv
rtl/core/lvps_back.sv
rtl/core/local_variance_pixel_select.sv
rtl/core/lvps_checker.sv
bench/local_variance_pixel_select_tb.sv
